// ----- hdl/voice_command_frame_builder_defines.svh -----
// Assertion macros shared by the frame builder's checker.
// No dependencies; include with the bare file name.
`ifndef VOICE_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define VOICE_COMMAND_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VCFB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame builder same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define VCFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame builder next-cycle check failed");

`endif

// ----- hdl/vcfb_pkg.sv -----
// Types and frame constants of the voice command frame builder.
// No dependencies; used by the top level and its checker.
package vcfb_pkg;

  localparam logic [7:0] FRAME_HEAD = 8'hAA;
  localparam logic [7:0] FRAME_TAIL = 8'h55;
  localparam logic [7:0] CMD_TEXT   = 8'h01;
  localparam logic [7:0] CMD_NUMBER = 8'h02;
  localparam logic [7:0] NUMBER_LEN = 8'h01;
  localparam logic [7:0] ERROR_BYTE = 8'h00;

  // Input kind carried in the slave-side tuser bit.
  localparam logic MODE_TEXT = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HEAD = 8'b0000_0010,
    S_CMD  = 8'b0000_0100,
    S_LEN  = 8'b0000_1000,
    S_TEXT = 8'b0001_0000,
    S_ID   = 8'b0010_0000,
    S_TAIL = 8'b0100_0000,
    S_ERR  = 8'b1000_0000
  } state_t;

endpackage

// ----- hdl/vcfb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the buffered text of the frame builder.
module vcfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 60
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/voice_command_frame_builder.sv -----
// Channel  | Signals                                   | Contents
// s_axis   | tvalid tready tdata[15:0] tuser[0]        | prompt_id, text_byte; mode
// m_axis   | tvalid tready tdata[7:0] tlast tuser[0]   | frame_byte; last_byte; failed
// cfg      | cfg_wr_en cfg_wr_data                     | spk_ready
//
// A text byte request is written straight into the text RAM; a zero byte, or one
// that finds the buffer full, is dropped. An end request yields its result bytes:
// 5 for a numbered frame, 4 plus the text length for a text frame, 1 for an error;
// input reopens after the last byte is loaded. The RAM is read one byte ahead while
// text is sent. Output stalls hold the sequencer in place. Reset is synchronous and
// needs no clearing pass: the text count alone says which RAM entries hold text.
module voice_command_frame_builder #(
  parameter int MAX_TEXT = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] prompt_id, [15:8] text_byte
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast,   // last_byte
  output logic        m_axis_tuser    // [0] failed
);

  import vcfb_pkg::*;

  localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int CW = $clog2(MAX_TEXT + 1);

  state_t          state, state_next;
  logic            spk_ready;
  logic [CW-1:0]   text_count;
  logic [7:0]      end_id;
  logic            use_text;
  logic [AW-1:0]   rd_idx;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;
  logic            in_fire, in_end, wr_en, out_free, advance, last_text;
  logic [7:0]      in_id, in_char;
  logic [7:0]      byte_val;
  logic            byte_last, byte_fail;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_end   = (s_axis_tuser == MODE_END);
  assign in_id    = s_axis_tdata[7:0];
  assign in_char  = s_axis_tdata[15:8];
  assign wr_en    = in_fire && !in_end && (in_char != 8'd0) &&
                    (text_count != CW'(MAX_TEXT));
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign advance  = out_free && (state != S_IDLE);
  assign last_text = ((CW'(rd_idx) + CW'(1)) == text_count);

  // The read address runs one byte ahead of the byte being sent, so rdata
  // always holds the entry at rd_idx while the sequencer is in S_TEXT.
  always_comb begin
    if (state == S_TEXT) begin
      raddr = advance ? rd_idx + AW'(1) : rd_idx;
    end else begin
      raddr = '0;
    end
  end

  vcfb_ram #(
    .WIDTH (8),
    .DEPTH (MAX_TEXT)
  ) u_text_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (text_count[AW-1:0]),
    .wr_data (in_char),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  always_comb begin
    state_next = state;
    byte_val   = ERROR_BYTE;
    byte_last  = 1'b0;
    byte_fail  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire && in_end) begin
          state_next = spk_ready ? S_HEAD : S_ERR;
        end
      end
      S_HEAD: begin
        byte_val = FRAME_HEAD;
        if (out_free) state_next = S_CMD;
      end
      S_CMD: begin
        byte_val = use_text ? CMD_TEXT : CMD_NUMBER;
        if (out_free) state_next = S_LEN;
      end
      S_LEN: begin
        byte_val = use_text ? (8'(text_count) + 8'd1) : NUMBER_LEN;
        if (out_free) state_next = use_text ? S_TEXT : S_ID;
      end
      S_TEXT: begin
        byte_val = rdata;
        if (out_free && last_text) state_next = S_TAIL;
      end
      S_ID: begin
        byte_val = end_id;
        if (out_free) state_next = S_TAIL;
      end
      S_TAIL: begin
        byte_val  = FRAME_TAIL;
        byte_last = 1'b1;
        if (out_free) state_next = S_IDLE;
      end
      S_ERR: begin
        byte_val  = ERROR_BYTE;
        byte_last = 1'b1;
        byte_fail = 1'b1;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      spk_ready     <= 1'b0;
      text_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        spk_ready <= cfg_wr_data;
      end
      // Every end request empties the buffer once its result is loaded.
      if ((state == S_TAIL || state == S_ERR) && advance) begin
        text_count <= '0;
      end else if (wr_en) begin
        text_count <= text_count + CW'(1);
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= raddr;
    if (in_fire && in_end) begin
      end_id   <= in_id;
      use_text <= (in_id == 8'd0) && (text_count != '0);
    end
    if (advance) begin
      m_axis_tdata <= byte_val;
      m_axis_tlast <= byte_last;
      m_axis_tuser <= byte_fail;
    end
  end

endmodule

// ----- hdl/vcfb_checker.sv -----
// Port-level checker for the voice command frame builder, with its bind.
// Depends on vcfb_pkg and voice_command_frame_builder_defines.svh.
`include "voice_command_frame_builder_defines.svh"

module vcfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  import vcfb_pkg::*;

  // An error result is a single zero byte that also closes the response.
  `VCFB_ASSERT_SAME(a_error_shape, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == ERROR_BYTE))

  // Every frame ends with the tail byte.
  `VCFB_ASSERT_SAME(a_frame_tail, clk, rst, m_axis_tvalid && m_axis_tlast && !m_axis_tuser, m_axis_tdata == FRAME_TAIL)

  // Within a frame the byte after a non-final byte is never an error result.
  `VCFB_ASSERT_NEXT(a_no_error_mid_frame, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !(m_axis_tvalid && m_axis_tuser))

  // A stalled result stays offered.
  `VCFB_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind voice_command_frame_builder vcfb_checker u_vcfb_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for voice_command_frame_builder: directed and random requests.
// Results are predicted in the testbench and compared byte by byte with the frames.
// Depends on vcfb_pkg and the voice_command_frame_builder top level only.
`timescale 1ns / 1ps

module tb;
  import vcfb_pkg::*;

  localparam int TEXT_LIMIT   = 60;
  localparam int ITEM_TARGET  = 130;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       failed;
  } frame_out_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] prompt_id, [15:8] text_byte
  logic        s_axis_tuser;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] frame_byte
  logic        m_axis_tlast;   // last_byte
  logic        m_axis_tuser;   // [0] failed

  // Predicted state of the block.
  logic [7:0]  text_buf [TEXT_LIMIT];
  int          model_len;
  logic        speech_ready;
  frame_out_t  pending_frame_bytes [$];

  int          mismatch_count;
  int          cycle_count;
  int          burst_left;
  int          sent_items;

  voice_command_frame_builder #(
    .MAX_TEXT(TEXT_LIMIT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL voice_command_frame_builder");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic void push_frame_byte(input logic [7:0] b, input logic last);
    frame_out_t fo;
    fo.frame_byte = b;
    fo.last_byte  = last;
    fo.failed     = 1'b0;
    pending_frame_bytes.push_back(fo);
  endfunction

  // Updates the text buffer and queues the frame bytes that one request causes.
  function automatic void predict_command_frame(input logic mode, input logic [7:0] id,
                                                input logic [7:0] ch);
    frame_out_t fo;
    if (mode == MODE_TEXT) begin
      if (ch != 8'h00 && model_len < TEXT_LIMIT) begin
        text_buf[model_len] = ch;
        model_len++;
      end
      return;
    end
    if (!speech_ready) begin
      fo.frame_byte = ERROR_BYTE;
      fo.last_byte  = 1'b1;
      fo.failed     = 1'b1;
      pending_frame_bytes.push_back(fo);
      model_len = 0;
      return;
    end
    push_frame_byte(FRAME_HEAD, 1'b0);
    if (id == 8'h00 && model_len > 0) begin
      push_frame_byte(CMD_TEXT, 1'b0);
      push_frame_byte(8'(model_len + 1), 1'b0);
      for (int i = 0; i < model_len; i++) begin
        push_frame_byte(text_buf[i], 1'b0);
      end
    end else begin
      push_frame_byte(CMD_NUMBER, 1'b0);
      push_frame_byte(NUMBER_LEN, 1'b0);
      push_frame_byte(id, 1'b0);
    end
    push_frame_byte(FRAME_TAIL, 1'b1);
    model_len = 0;
  endfunction

  // Sends one request; the sender runs in bursts with random gaps between them.
  task automatic send_request(input logic mode, input logic [7:0] id, input logic [7:0] ch);
    int  gap;
    bit  took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ch, id};
    s_axis_tuser  <= mode;
    // Ready is stable from the falling edge until the next rising edge.
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    burst_left--;
    sent_items++;
    predict_command_frame(mode, id, ch);
  endtask

  task automatic send_text(input logic [7:0] ch);
    send_request(MODE_TEXT, 8'($urandom_range(0, 255)), ch);
  endtask

  task automatic send_end(input logic [7:0] id);
    send_request(MODE_END, id, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
  endtask

  // Writes the ready register once the block has sent everything it owes.
  task automatic set_speech_ready(input logic value);
    wait_drained();
    repeat (6) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    speech_ready = value;
  endtask

  task automatic test_error_when_not_ready();
    send_text(8'h41);
    send_text(8'h42);
    send_end(8'h00);
    send_end(8'h07);
  endtask

  task automatic test_numbered_frames();
    set_speech_ready(1'b1);
    send_end(8'h00);
    send_end(8'hFF);
    send_end(8'h5A);
    // Text followed by a nonzero id still yields the numbered frame.
    send_text(8'hA5);
    send_end(8'h01);
    send_end(8'h00);
  endtask

  task automatic test_text_frames();
    send_text(8'hFF);
    send_end(8'h00);
    send_text(8'h01);
    send_text(8'h00);
    send_text(8'h80);
    send_text(8'h7F);
    send_text(8'hFE);
    send_end(8'h00);
  endtask

  task automatic test_text_discarded_on_error();
    send_text(8'h33);
    set_speech_ready(1'b0);
    send_end(8'h00);
    set_speech_ready(1'b1);
    send_end(8'h00);
  endtask

  // Well-formed text requests with random content, plus some noise and
  // register changes between requests.
  task automatic test_random_requests();
    int          len;
    bit          first;
    logic [7:0]  ch;
    logic [7:0]  id;
    first = 1'b1;
    while (sent_items < ITEM_TARGET) begin
      if (!first && $urandom_range(0, 5) == 0) begin
        set_speech_ready($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
      if ($urandom_range(0, 9) == 0) begin
        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end
      // The first run of text requests overruns the text buffer.
      if (first) begin
        len = $urandom_range(TEXT_LIMIT + 1, TEXT_LIMIT + 6);
      end else if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(40, TEXT_LIMIT + 6);
      end else begin
        len = $urandom_range(0, 8);
      end
      first = 1'b0;
      for (int i = 0; i < len; i++) begin
        ch = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        send_request(MODE_TEXT, 8'($urandom_range(0, 255)), ch);
      end
      id = ($urandom_range(0, 2) != 0) ? 8'h00 : 8'($urandom_range(0, 255));
      send_request(MODE_END, id, 8'($urandom_range(0, 255)));
    end
  endtask

  // The receiver switches between stall patterns: always ready, random ready and two periodic patterns.
  initial begin
    int stall_kind;
    int span;
    m_axis_tready <= 1'b0;
    forever begin
      stall_kind = $urandom_range(0, 3);
      span = $urandom_range(16, 64);
      for (int n = 0; n < span; n++) begin
        @(posedge clk);
        case (stall_kind)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            m_axis_tready <= (n % 4 != 3);
          end
          default: begin
            m_axis_tready <= (n % 8 < 2);
          end
        endcase
      end
    end
  end

  // Output and ready only change at rising edges, so the falling edge sees
  // the values that the next rising edge will take.
  always @(negedge clk) begin
    frame_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h", m_axis_tdata));
      end else begin
        want = pending_frame_bytes.pop_front();
        if (m_axis_tdata !== want.frame_byte) begin
          report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                    m_axis_tdata, want.frame_byte));
        end
        if (m_axis_tlast !== want.last_byte) begin
          report_mismatch($sformatf("last_byte %b, expected %b",
                                    m_axis_tlast, want.last_byte));
        end
        if (m_axis_tuser !== want.failed) begin
          report_mismatch($sformatf("failed %b, expected %b",
                                    m_axis_tuser, want.failed));
        end
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= MODE_TEXT;
    cycle_count    = 0;
    mismatch_count = 0;
    burst_left     = 0;
    sent_items     = 0;
    model_len      = 0;
    speech_ready   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_error_when_not_ready();
    test_numbered_frames();
    test_text_frames();
    test_text_discarded_on_error();
    test_random_requests();

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
      $display("PASS voice_command_frame_builder");
    end else begin
      $display("FAIL voice_command_frame_builder");
    end
    $finish;
  end

endmodule
